// File: src/gcn_pkg.sv
// ----------------------------------------------------------------------------
// gcn_pkg: shared types and constants of the grid coverage navigator
// Holds the heading and action codes, the controller states, the command
// and status groups between controller and datapath, and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package gcn_pkg;

	// Heading codes: north is y-1, east x+1, south y+1, west x-1.
	typedef enum logic [1:0] {
		DIR_NORTH = 2'd0,
		DIR_EAST  = 2'd1,
		DIR_SOUTH = 2'd2,
		DIR_WEST  = 2'd3
	} dir_t;

	// Action codes of a result item.
	typedef enum logic [1:0] {
		ACT_STOP    = 2'd0,
		ACT_BACKUP  = 2'd1,
		ACT_FORWARD = 2'd2
	} action_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MARK,
		ST_SCAN,
		ST_MOVE,
		ST_HALT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;     // clear one map cell, advance the sweep counter
		logic capture;   // latch the reading of an accepted item
		logic mark;      // mark the current cell and restart the scan
		logic scan;      // issue one map read and check the previous one
		logic set_goal;  // take the cell just found as the new target
		logic step;      // do the move or avoid step and load the result
		logic halt;      // enter the halted state and load a stop result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic halted;
		logic goal_valid;
		logic scan_found;
		logic scan_exhausted;
	} status_t;

	// Register map of the configuration port. Registers are 32-bit words,
	// so the word index sits above the two byte-offset bits.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
	localparam logic [PADDR_W-3:0] IDX_THRESHOLD  = 1'd0;
	localparam logic [7:0] THRESHOLD_RESET = 8'd20;

endpackage

`default_nettype wire

// File: src/gcn_ram.sv
// ----------------------------------------------------------------------------
// gcn_ram: generic memory with one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gcn_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, and read with the data registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/gcn_datapath.sv
// ----------------------------------------------------------------------------
// gcn_datapath: position, target, visited map and result register
// Executes the controller's commands: the map clearing sweep, the marking
// of the current cell, the column-major scan for an unvisited cell and the
// move or avoid step with clamping at the grid edges.
// ----------------------------------------------------------------------------
`default_nettype none

module gcn_datapath #(
	parameter int unsigned GRID_W    = 16,
	parameter int unsigned GRID_H    = 16,
	parameter int unsigned MAX_RANGE = 200
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gcn_pkg::cmd_t  cmd,
	output gcn_pkg::status_t    status,
	input  wire logic [7:0]     distance_cm,
	input  wire logic [7:0]     threshold,
	output logic      [1:0]     action,
	output logic      [1:0]     right_turns,
	output logic      [3:0]     pos_x,
	output logic      [3:0]     pos_y,
	output logic      [1:0]     heading,
	output logic                done_res
);

	localparam int unsigned NCELLS = GRID_W * GRID_H;
	localparam int unsigned AW     = $clog2(NCELLS);
	localparam int unsigned XW     = $clog2(GRID_W);
	localparam int unsigned YW     = $clog2(GRID_H);
	localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
	localparam logic [XW-1:0] X_MAX     = XW'(GRID_W - 1);
	localparam logic [YW-1:0] Y_MAX     = YW'(GRID_H - 1);

	// Architectural state.
	logic [XW-1:0]     cur_x_q, goal_x_q, nxt_x;
	logic [YW-1:0]     cur_y_q, goal_y_q, nxt_y;
	gcn_pkg::dir_t     heading_q, target;
	logic              goal_valid_q, halted_q;
	logic [7:0]        dist_q;

	// Sweep and scan counters, and the check stage behind the map read.
	logic [AW-1:0]     idx_q;
	logic [XW-1:0]     sx_q, chk_x_q;
	logic [YW-1:0]     sy_q, chk_y_q;
	logic              iss_done_q, chk_valid_q, chk_last_q;

	logic              map_we, map_wdata;
	logic [AW-1:0]     map_waddr, mark_addr;
	logic [0:0]        map_rdata;
	logic              obstacle, reached;
	logic [1:0]        turns;

	// Visited map: written by the sweep and by marking, read by the scan.
	assign mark_addr = AW'(32'(cur_x_q) * GRID_H + 32'(cur_y_q));
	assign map_we    = cmd.clear | cmd.mark;
	assign map_wdata = cmd.mark;
	assign map_waddr = cmd.mark ? mark_addr : idx_q;

	gcn_ram #(
		.WIDTH(1),
		.DEPTH(NCELLS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (idx_q),
		.rdata (map_rdata)
	);

	// Sweep counter, scan issue and the check stage that pairs with the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			iss_done_q  <= 1'b0;
			chk_valid_q <= 1'b0;
			chk_last_q  <= 1'b0;
			chk_x_q     <= '0;
			chk_y_q     <= '0;
		end else if (cmd.clear) begin
			idx_q <= (idx_q == LAST_CELL) ? '0 : idx_q + AW'(1);
		end else if (cmd.mark) begin
			idx_q       <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			iss_done_q  <= 1'b0;
			chk_valid_q <= 1'b0;
		end else if (cmd.scan) begin
			chk_valid_q <= ~iss_done_q;
			if (!iss_done_q) begin
				chk_x_q    <= sx_q;
				chk_y_q    <= sy_q;
				chk_last_q <= (idx_q == LAST_CELL);
				if (idx_q == LAST_CELL) begin
					iss_done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
				if (sy_q == Y_MAX) begin
					sy_q <= '0;
					sx_q <= sx_q + XW'(1);
				end else begin
					sy_q <= sy_q + YW'(1);
				end
			end
		end
	end

	// Obstacle test; readings beyond the sensor range count as no echo.
	assign obstacle = (32'(dist_q) <= 32'(MAX_RANGE)) && (dist_q != 8'd0) &&
	                  (dist_q < threshold);

	// Heading toward the target and the clamped cell one step ahead.
	always_comb begin
		if (cur_x_q < goal_x_q) begin
			target = gcn_pkg::DIR_EAST;
		end else if (cur_x_q > goal_x_q) begin
			target = gcn_pkg::DIR_WEST;
		end else if (cur_y_q < goal_y_q) begin
			target = gcn_pkg::DIR_SOUTH;
		end else begin
			target = gcn_pkg::DIR_NORTH;
		end
		nxt_x = cur_x_q;
		nxt_y = cur_y_q;
		case (target)
			gcn_pkg::DIR_NORTH: begin
				if (cur_y_q != '0) nxt_y = cur_y_q - YW'(1);
			end
			gcn_pkg::DIR_EAST: begin
				if (cur_x_q != X_MAX) nxt_x = cur_x_q + XW'(1);
			end
			gcn_pkg::DIR_SOUTH: begin
				if (cur_y_q != Y_MAX) nxt_y = cur_y_q + YW'(1);
			end
			default: begin
				if (cur_x_q != '0) nxt_x = cur_x_q - XW'(1);
			end
		endcase
		turns   = 2'(target - heading_q);
		reached = (nxt_x == goal_x_q) && (nxt_y == goal_y_q);
	end

	// Position, heading, target and halt flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			heading_q    <= gcn_pkg::DIR_NORTH;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			goal_valid_q <= 1'b0;
			halted_q     <= 1'b0;
		end else begin
			if (cmd.set_goal) begin
				goal_x_q     <= chk_x_q;
				goal_y_q     <= chk_y_q;
				goal_valid_q <= 1'b1;
			end
			if (cmd.step) begin
				if (obstacle) begin
					heading_q <= gcn_pkg::dir_t'(2'(heading_q + 2'd1));
				end else begin
					heading_q <= target;
					cur_x_q   <= nxt_x;
					cur_y_q   <= nxt_y;
					if (reached) goal_valid_q <= 1'b0;
				end
			end
			if (cmd.halt) begin
				halted_q <= 1'b1;
			end
		end
	end

	// Reading of the item in hand.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dist_q <= distance_cm;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			done_res <= 1'b0;
			if (obstacle) begin
				action      <= gcn_pkg::ACT_BACKUP;
				right_turns <= 2'd1;
				pos_x       <= 4'(cur_x_q);
				pos_y       <= 4'(cur_y_q);
				heading     <= 2'(heading_q + 2'd1);
			end else begin
				action      <= gcn_pkg::ACT_FORWARD;
				right_turns <= turns;
				pos_x       <= 4'(nxt_x);
				pos_y       <= 4'(nxt_y);
				heading     <= target;
			end
		end else if (cmd.halt) begin
			action      <= gcn_pkg::ACT_STOP;
			right_turns <= 2'd0;
			pos_x       <= 4'(cur_x_q);
			pos_y       <= 4'(cur_y_q);
			heading     <= heading_q;
			done_res    <= 1'b1;
		end
	end

	// Status to the controller.
	always_comb begin
		status.clear_last     = (idx_q == LAST_CELL);
		status.halted         = halted_q;
		status.goal_valid     = goal_valid_q;
		status.scan_found     = chk_valid_q & ~map_rdata[0];
		status.scan_exhausted = chk_valid_q & map_rdata[0] & chk_last_q;
	end

endmodule

`default_nettype wire

// File: src/gcn_controller.sv
// ----------------------------------------------------------------------------
// gcn_controller: sequencer of the grid coverage navigator
// Runs the map clearing sweep after reset, takes one item at a time,
// orders marking, scan, step and halt, and owns the valid flag of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gcn_controller (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire gcn_pkg::status_t status,
	output gcn_pkg::cmd_t         cmd
);

	gcn_pkg::state_t state_q, state_nxt;
	logic            out_free, load_out;

	// The result register may be loaded when empty or being taken.
	assign out_free = ~out_valid | ~out_stall;
	assign load_out = cmd.step | cmd.halt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcn_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			gcn_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) state_nxt = gcn_pkg::ST_IDLE;
			end
			gcn_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (status.halted) begin
						state_nxt = gcn_pkg::ST_HALT;
					end else if (status.goal_valid) begin
						state_nxt = gcn_pkg::ST_MOVE;
					end else begin
						state_nxt = gcn_pkg::ST_MARK;
					end
				end
			end
			gcn_pkg::ST_MARK: begin
				cmd.mark  = 1'b1;
				state_nxt = gcn_pkg::ST_SCAN;
			end
			gcn_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_found) begin
					cmd.set_goal = 1'b1;
					state_nxt    = gcn_pkg::ST_MOVE;
				end else if (status.scan_exhausted) begin
					state_nxt = gcn_pkg::ST_HALT;
				end
			end
			gcn_pkg::ST_MOVE: begin
				if (out_free) begin
					cmd.step  = 1'b1;
					state_nxt = gcn_pkg::ST_IDLE;
				end
			end
			gcn_pkg::ST_HALT: begin
				if (out_free) begin
					cmd.halt  = 1'b1;
					state_nxt = gcn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = gcn_pkg::ST_IDLE;
			end
		endcase
	end

	// A new result only ever comes from a step or a halt.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == gcn_pkg::ST_MOVE ||
		                      $past(state_q) == gcn_pkg::ST_HALT))
		else $error("result appeared outside a step or halt");

	// Once halted, an accepted item goes straight to a stop result.
	a_halt_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gcn_pkg::ST_IDLE && in_valid && status.halted)
		|=> state_q == gcn_pkg::ST_HALT)
		else $error("halted block did not answer with stop");

	// Marking happens only without a target and before halting.
	a_mark_needs_no_goal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcn_pkg::ST_MARK |-> (!status.goal_valid && !status.halted))
		else $error("cell marked while a target was held");

	// A result is never overwritten while it waits to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !load_out)
		else $error("waiting result overwritten");

endmodule

`default_nettype wire

// File: src/grid_coverage_navigator.sv
// ----------------------------------------------------------------------------
// grid_coverage_navigator: coverage navigation over a grid of cells
// Takes one range reading per item and answers with one move command,
// keeping a visited map, the position, the heading and the target cell.
//
//   Channel   Signals                                   Direction
//   config    psel penable pwrite paddr pwdata prdata   APB-style, in/out
//   input     in_valid in_stall distance_cm             item in
//   output    out_valid out_stall action right_turns    item out
//             pos_x pos_y heading done_res
//
// After reset a clearing pass over all GRID_W*GRID_H cells empties the visited
// map; no item is accepted during it.
// An item with a target in hand goes straight to the move step; one that needs a
// new target first marks its cell and scans the visited map through its single
// read port, one cell per cycle.
// Items are handled one at a time; the next is accepted while a result
// waits in the output register, and a stalled result holds the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_coverage_navigator #(
	parameter int unsigned GRID_W    = 16,
	parameter int unsigned GRID_H    = 16,
	parameter int unsigned MAX_RANGE = 200
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [gcn_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [gcn_pkg::PDATA_W-1:0]   pwdata,
	output logic      [gcn_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    distance_cm,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [1:0]                    action,
	output logic      [1:0]                    right_turns,
	output logic      [3:0]                    pos_x,
	output logic      [3:0]                    pos_y,
	output logic      [1:0]                    heading,
	output logic                               done_res
);

	logic [7:0]        threshold_q;
	gcn_pkg::cmd_t     cmd;
	gcn_pkg::status_t  status;

	// Obstacle threshold register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= gcn_pkg::THRESHOLD_RESET;
		end else if (psel && penable && pwrite &&
		             paddr[gcn_pkg::PADDR_W-1:2] == gcn_pkg::IDX_THRESHOLD) begin
			threshold_q <= pwdata[7:0];
		end
	end

	// Read back.
	always_comb begin
		prdata = '0;
		if (paddr[gcn_pkg::PADDR_W-1:2] == gcn_pkg::IDX_THRESHOLD) begin
			prdata = gcn_pkg::PDATA_W'(threshold_q);
		end
	end

	gcn_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gcn_datapath #(
		.GRID_W    (GRID_W),
		.GRID_H    (GRID_H),
		.MAX_RANGE (MAX_RANGE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.distance_cm (distance_cm),
		.threshold   (threshold_q),
		.action      (action),
		.right_turns (right_turns),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.heading     (heading),
		.done_res    (done_res)
	);

endmodule

`default_nettype wire
